>>> rtl/gconn_pkg.sv
// gconn_pkg: shared constants, state encoding and control structs for the
// graph connectivity check unit. No dependencies.
`timescale 1ns / 1ps

package gconn_pkg;

    // Default graph size; the top level parameter takes it from here.
    localparam int MAX_VERTICES_DEF = 64;

    // Fixed word field widths.
    localparam int ROW_INDEX_W    = 6;
    localparam int ROW_BITS_W     = 64;
    localparam int VERTEX_COUNT_W = 7;
    localparam int START_W        = 6;
    localparam int UNREACHED_W    = 7;

    // Word kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    // Walk sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_MERGE = 4'b0100,
        S_DONE  = 4'b1000
    } walk_state_t;

    // Top level to walk sequencer.
    typedef struct packed {
        logic go;        // run word accepted this cycle
        logic start_ok;  // start vertex lies below the vertex count
        logic out_free;  // output register can take a result
    } walk_ctl_t;

    // Walk sequencer to top level.
    typedef struct packed {
        logic idle;      // ready for the next word
        logic done;      // result valid this cycle
    } walk_sts_t;

endpackage

>>> rtl/graph_connectivity_check_unit.sv
// graph_connectivity_check_unit: top level. Word decode, vertex count clamp,
// row store, walk sequencer and output register.
// Depends on gconn_pkg, gconn_row_mem, gconn_walk.
`timescale 1ns / 1ps

// Graph connectivity checker. Load words (kind 0) write one adjacency row
// bitmask per word into the row store; bit i of row v means an edge from v to
// i. Loads to a row index at or above MAX_VERTICES are dropped. A run word
// (kind 1) walks every vertex reachable from start_vertex, looking only at
// row bits below vertex_count, and returns one result word: connected, and
// how many vertices were not reached. vertex_count 0 acts as 1 and counts
// above MAX_VERTICES saturate; a start vertex at or above the count reaches
// nothing. Rows touched by a run must have been loaded before. During a run
// one scan pointer steps over the pending mask one vertex per cycle, pausing
// while each newly reached vertex takes a row read and a merge through the
// single read port of the row store. A finished run waits in its done state
// until the output register can take the result. in_stall is high for the
// whole run; a finished result sits in the output register, so load words are
// taken again while it waits.

module graph_connectivity_check_unit
    import gconn_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input words
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       kind,
    input  logic [ROW_INDEX_W-1:0]     row_index,
    input  logic [ROW_BITS_W-1:0]      row_bits,
    input  logic [VERTEX_COUNT_W-1:0]  vertex_count,
    input  logic [START_W-1:0]         start_vertex,
    // result words
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       connected,
    output logic [UNREACHED_W-1:0]     unreached_count
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    logic                          in_fire;
    logic                          load_en;
    logic [VERTEX_COUNT_W-1:0]     n_full;
    logic [CW-1:0]                 n_eff;
    walk_ctl_t                     ctl;
    walk_sts_t                     sts;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [MAX_VERTICES-1:0]       rd_data;
    logic                          res_connected;
    logic [CW-1:0]                 res_unreached;

    logic                          out_valid_reg, out_valid_next;
    logic                          connected_reg;
    logic [UNREACHED_W-1:0]        unreached_reg;

    assign in_stall = !sts.idle;
    assign in_fire  = in_valid && !in_stall;

    // loads past the store depth are dropped
    assign load_en = in_fire && (kind == KIND_LOAD)
                     && ({1'b0, row_index} < VERTEX_COUNT_W'(MAX_VERTICES));

    // clamp vertex count to 1..MAX_VERTICES
    always_comb
    begin
        if (vertex_count == '0)
        begin
            n_full = VERTEX_COUNT_W'(1);
        end
        else if (vertex_count > VERTEX_COUNT_W'(MAX_VERTICES))
        begin
            n_full = VERTEX_COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_full = vertex_count;
        end
    end

    assign n_eff        = n_full[CW-1:0];
    assign ctl.go       = in_fire && (kind == KIND_RUN);
    assign ctl.start_ok = ({1'b0, start_vertex} < n_full);
    assign ctl.out_free = !out_valid_reg || !out_stall;

    gconn_row_mem #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES),
        .AW    (AW)
    ) u_row_mem (
        .clk   (clk),
        .we    (load_en),
        .waddr (row_index[AW-1:0]),
        .wdata (row_bits[MAX_VERTICES-1:0]),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gconn_walk #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .CW           (CW)
    ) u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .n_eff         (n_eff),
        .start_idx     (start_vertex[AW-1:0]),
        .rd_data       (rd_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .sts           (sts),
        .res_connected (res_connected),
        .res_unreached (res_unreached)
    );

    // output register: filled when the walk finishes and the slot is free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sts.done && ctl.out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sts.done && ctl.out_free)
        begin
            connected_reg <= res_connected;
            unreached_reg <= UNREACHED_W'(res_unreached);
        end
    end

    assign out_valid       = out_valid_reg;
    assign connected       = connected_reg;
    assign unreached_count = unreached_reg;

endmodule

>>> rtl/gconn_row_mem.sv
// gconn_row_mem: adjacency row store, one write port and one registered
// read port. Depends on nothing.
`timescale 1ns / 1ps

module gconn_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gconn_walk.sv
// gconn_walk: walk sequencer. A scan pointer steps over the pending mask,
// pulls one adjacency row per visited vertex and merges it in.
// Depends on gconn_pkg; reads rows through gconn_row_mem.
`timescale 1ns / 1ps

module gconn_walk
    import gconn_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES),
    parameter int CW           = $clog2(MAX_VERTICES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  walk_ctl_t               ctl,
    input  logic [CW-1:0]           n_eff,
    input  logic [AW-1:0]           start_idx,
    input  logic [MAX_VERTICES-1:0] rd_data,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    output walk_sts_t               sts,
    output logic                    res_connected,
    output logic [CW-1:0]           res_unreached
);

    walk_state_t             state_reg, state_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] pending_reg, pending_next;
    logic [MAX_VERTICES-1:0] nmask_reg, nmask_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           reached_reg, reached_next;
    logic [AW-1:0]           ptr_reg, ptr_next;
    logic [AW-1:0]           ptr_adv;
    logic [MAX_VERTICES-1:0] ptr_bit;

    // next scan position, wrapping at the vertex count
    assign ptr_adv = (CW'(ptr_reg) == n_reg - CW'(1)) ? '0 : ptr_reg + AW'(1);
    assign ptr_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << ptr_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            nmask_next[i] = (i < int'(n_eff));
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        visited_next = visited_reg;
        pending_next = pending_reg;
        n_next       = n_reg;
        reached_next = reached_reg;
        ptr_next     = ptr_reg;
        rd_en        = 1'b0;
        rd_addr      = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (ctl.go)
                begin
                    n_next       = n_eff;
                    ptr_next     = '0;
                    pending_next = '0;
                    if (ctl.start_ok)
                    begin
                        visited_next = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << start_idx;
                        reached_next = CW'(1);
                        rd_en        = 1'b1;
                        rd_addr      = start_idx;
                        state_next   = S_MERGE;
                    end
                    else
                    begin
                        // start outside the graph: nothing reached
                        visited_next = '0;
                        reached_next = '0;
                        state_next   = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (pending_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if ((pending_reg & ptr_bit) != '0)
                begin
                    pending_next = pending_reg & ~ptr_bit;
                    visited_next = visited_reg | ptr_bit;
                    reached_next = reached_reg + CW'(1);
                    rd_en        = 1'b1;
                    state_next   = S_MERGE;
                end
                else
                begin
                    ptr_next = ptr_adv;
                end
            end
            S_MERGE:
            begin
                // row data arrives in the cycle after the read, from the registered port
                pending_next = pending_reg | (rd_data & nmask_reg & ~visited_reg);
                ptr_next     = ptr_adv;
                state_next   = S_SCAN;
            end
            S_DONE:
            begin
                if (ctl.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            visited_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && ctl.go)
        begin
            nmask_reg <= nmask_next;
        end
        n_reg       <= n_next;
        reached_reg <= reached_next;
        ptr_reg     <= ptr_next;
    end

    assign sts.idle      = (state_reg == S_IDLE);
    assign sts.done      = (state_reg == S_DONE);
    assign res_connected = (reached_reg == n_reg);
    assign res_unreached = n_reg - reached_reg;

endmodule
